>>> rtl/core/agc_pkg.sv
// Shared types, constants and register codes of the receive gain control block.
package agc_pkg;

   // Default values of the top-level parameters
   localparam int SMOOTH_SHIFT_DEF  = 3;
   localparam int FRACTION_BITS_DEF = 6;
   localparam int QUEUE_DEPTH_DEF   = 2;

   // Field widths
   localparam int POWER_W     = 8;
   localparam int ERR_W       = 16;
   localparam int GAIN_W      = 10;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int MUL_B_W     = 10;
   localparam int PROD_W      = ERR_W + MUL_B_W + 1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_TARGET = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEPS_PER_DB = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_SLOPE    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_UPPER   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_LOWER   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DOWN     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTH_MULT  = 3'd6;

   // Opcodes
   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_UPDATE  = 1'b1;

   // Gain code after reset: least amplifier gain
   localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd1023;

   typedef struct packed {
      logic signed [7:0] power_target_db;
      logic [5:0]        gain_step_rate;
      logic [9:0]        inverse_slope;
      logic [9:0]        gain_code_upper;
      logic [9:0]        gain_code_lower;
      logic [6:0]        max_down_step_db;
      logic [7:0]        smooth_multiplier;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      power_target_db:   -8'sd60,
      gain_step_rate:    6'd4,
      inverse_slope:     10'd64,
      gain_code_upper:   10'd1023,
      gain_code_lower:   10'd0,
      max_down_step_db:  7'd10,
      smooth_multiplier: 8'd7
   };

   // Classified command word: opcode and the floored, scaled power error
   typedef struct packed {
      logic                    opcode;
      logic signed [ERR_W-1:0] clip_error;
   } cmd_type;

   // Head of the command queue as seen by the execution side
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

endpackage

>>> rtl/core/agc_front.sv
// Front end: configuration registers, input acceptance and measurement pre-scaling.
module agc_front #(
   parameter int FRACTION_BITS = agc_pkg::FRACTION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic signed [agc_pkg::POWER_W-1:0]  req_rx_power_db,
   input  logic                                csr_write_enable,
   input  logic [agc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [agc_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                queue_full,
   output logic                                queue_push,
   output agc_pkg::cmd_type                    queue_cmd,
   output agc_pkg::cfg_type                    cfg
);
   import agc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic signed [POWER_W:0]  diff;
   logic signed [ERR_W:0]    diff_shift;
   logic signed [ERR_W-1:0]  adj;
   logic [ERR_W:0]           down_mag;
   logic signed [ERR_W-1:0]  floor_val;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POWER_TARGET: cfg_in.power_target_db   = signed'(csr_write_data[7:0]);
            CSR_STEPS_PER_DB: cfg_in.gain_step_rate    = csr_write_data[5:0];
            CSR_INV_SLOPE:    cfg_in.inverse_slope     = csr_write_data[9:0];
            CSR_GAIN_UPPER:   cfg_in.gain_code_upper   = csr_write_data[9:0];
            CSR_GAIN_LOWER:   cfg_in.gain_code_lower   = csr_write_data[9:0];
            CSR_MAX_DOWN:     cfg_in.max_down_step_db  = csr_write_data[6:0];
            CSR_SMOOTH_MULT:  cfg_in.smooth_multiplier = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   // Scale the power error to fractional dB and floor it at the largest down step
   always_comb begin
      diff       = (POWER_W+1)'(req_rx_power_db) - (POWER_W+1)'(cfg_ff.power_target_db);
      diff_shift = (ERR_W+1)'(diff) <<< FRACTION_BITS;
      adj        = signed'(diff_shift[ERR_W-1:0]);
      // the floor magnitude stays below 2^15 for every legal fraction width
      down_mag   = (ERR_W+1)'(cfg_ff.max_down_step_db) << FRACTION_BITS;
      floor_val  = signed'(ERR_W'((ERR_W+1)'(0) - down_mag));
   end

   // Accept a word whenever the queue has room
   assign req_ready            = !queue_full;
   assign queue_push           = req_valid && !queue_full;
   assign queue_cmd.opcode     = req_opcode;
   assign queue_cmd.clip_error = (adj > floor_val) ? adj : floor_val;

endmodule

>>> rtl/core/agc_queue.sv
// Short command queue between the front end and the execution side.
module agc_queue #(
   parameter int DEPTH = agc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  agc_pkg::cmd_type   push_cmd,
   output logic               full,
   input  logic               pop,
   output agc_pkg::qhead_type head
);
   import agc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && (count_ff != '0);

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem_ff[rd_ptr_ff];

endmodule

>>> rtl/core/agc_back.sv
// Execution side: sequencer around one shared multiplier, state and result register.
module agc_back #(
   parameter int SMOOTH_SHIFT  = agc_pkg::SMOOTH_SHIFT_DEF,
   parameter int FRACTION_BITS = agc_pkg::FRACTION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  agc_pkg::cfg_type                    cfg,
   input  agc_pkg::qhead_type                  head,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [agc_pkg::ERR_W-1:0]    rsp_smoothed_error,
   output logic [agc_pkg::GAIN_W-1:0]          rsp_gain_code
);
   import agc_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_ACC  = 3'd2;
   localparam logic [2:0] S_CORR = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;
   localparam int         ACC_W  = PROD_W + 1;

   logic [2:0]               state_ff, state_in;
   logic                     op_ff, op_in;
   logic signed [ERR_W-1:0]  clip_ff, clip_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ERR_W-1:0]  delta_ff, delta_in;
   logic signed [ERR_W-1:0]  smoothed_ff, smoothed_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [ERR_W-1:0]  rsp_err_ff, rsp_err_in;
   logic [GAIN_W-1:0]        rsp_gain_ff, rsp_gain_in;

   logic                     out_free, load_rsp;
   logic signed [ERR_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]       mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [ERR_W-1:0]  db;
   logic signed [ACC_W-1:0]  acc, acc_sh;
   logic signed [ERR_W-1:0]  delta_raw, test, upper16, lower16;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = (state_ff == S_IDLE) && head.valid && out_free;
   assign db       = smoothed_ff >>> FRACTION_BITS;

   // Select multiplier operands for the current step
   always_comb begin
      mul_a = smoothed_ff;
      mul_b = MUL_B_W'(cfg.smooth_multiplier);
      if (state_ff == S_CORR) begin
         mul_a = delta_ff;
         mul_b = cfg.inverse_slope;
      end else if (op_ff == OP_UPDATE) begin
         mul_a = db;
         mul_b = MUL_B_W'(cfg.gain_step_rate);
      end
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(signed'({1'b0, mul_b}));

   // Filter sum and gain clamp arithmetic
   always_comb begin
      acc       = ACC_W'(prod_ff) + ACC_W'(clip_ff);
      acc_sh    = acc >>> SMOOTH_SHIFT;
      delta_raw = signed'(prod_ff[ERR_W-1:0]);
      test      = signed'(ERR_W'({6'b0, gain_ff}) + delta_raw);
      upper16   = signed'(ERR_W'({6'b0, cfg.gain_code_upper}));
      lower16   = signed'(ERR_W'({6'b0, cfg.gain_code_lower}));
   end

   // Sequence one word through the shared multiplier
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      clip_in     = clip_ff;
      prod_in     = prod_ff;
      delta_in    = delta_ff;
      smoothed_in = smoothed_ff;
      gain_in     = gain_ff;
      load_rsp    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (pop) begin
               op_in    = head.cmd.opcode;
               clip_in  = head.cmd.clip_error;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = mul_p;
            state_in = S_ACC;
         end
         S_ACC: begin
            if (op_ff == OP_MEASURE) begin
               smoothed_in = signed'(acc_sh[ERR_W-1:0]);
               load_rsp    = 1'b1;
               state_in    = S_IDLE;
            end else begin
               // the upper limit is checked first and wins when the sum exceeds both crossed limits
               priority if (test > upper16) begin
                  gain_in  = cfg.gain_code_upper;
                  delta_in = upper16 - signed'(ERR_W'({6'b0, gain_ff}));
               end else if (test < lower16) begin
                  gain_in  = cfg.gain_code_lower;
                  delta_in = lower16 - signed'(ERR_W'({6'b0, gain_ff}));
               end else begin
                  gain_in  = test[GAIN_W-1:0];
                  delta_in = delta_raw;
               end
               state_in = S_CORR;
            end
         end
         S_CORR: begin
            prod_in  = mul_p;
            state_in = S_DONE;
         end
         S_DONE: begin
            // remove the applied change, scaled back and shifted right by two
            smoothed_in = smoothed_ff - signed'(prod_ff[ERR_W+1:2]);
            load_rsp    = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_gain_in  = rsp_gain_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_err_in   = smoothed_in;
         rsp_gain_in  = gain_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         smoothed_ff  <= '0;
         gain_ff      <= GAIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         smoothed_ff  <= smoothed_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      clip_ff     <= clip_in;
      prod_ff     <= prod_in;
      delta_ff    <= delta_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_gain_ff <= rsp_gain_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_smoothed_error = rsp_err_ff;
   assign rsp_gain_code      = rsp_gain_ff;

endmodule

>>> rtl/core/receive_gain_agc_with_iir_smoothing.sv
// Top level of the receive gain control block with IIR-smoothed power error.
//
// Input channel (req_): one word per item. Opcode 0 folds rx_power_db into the
// smoothed power error; opcode 1 applies the error to the gain code. Every item
// returns one word on the result channel (rsp_) with the smoothed error in
// fractional dB and the gain code after that item.
// Configuration (csr_): write csr_write_data to register csr_index in one cycle
// while no item is in flight; an index beyond the last register is ignored.
// From acceptance an item passes the queue and the sequencer states idle, multiply
// and accumulate, plus correct and done for a gain update; the sequencer takes its
// next word only back in idle and runs every product through one shared multiplier.
// A command queue of QUEUE_DEPTH words takes new items while the sequencer works;
// req_ready drops only when that queue is full.
// Reset clears the smoothed error, sets the gain code to 1023, loads the
// register defaults and empties the queue and the result register.
// When the receiver holds rsp_ready low the result word holds, the sequencer
// waits before taking its next word, and the queue keeps filling until full.
module receive_gain_agc_with_iir_smoothing #(
   parameter int SMOOTH_SHIFT  = agc_pkg::SMOOTH_SHIFT_DEF,
   parameter int FRACTION_BITS = agc_pkg::FRACTION_BITS_DEF,
   parameter int QUEUE_DEPTH   = agc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic signed [agc_pkg::POWER_W-1:0]  req_rx_power_db,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [agc_pkg::ERR_W-1:0]    rsp_smoothed_error,
   output logic [agc_pkg::GAIN_W-1:0]          rsp_gain_code,
   input  logic                                csr_write_enable,
   input  logic [agc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [agc_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import agc_pkg::*;

   cfg_type   cfg;
   cmd_type   queue_cmd;
   qhead_type head;
   logic      queue_push, queue_full, queue_pop;

   agc_front #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_rx_power_db  (req_rx_power_db),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .queue_push       (queue_push),
      .queue_cmd        (queue_cmd),
      .cfg              (cfg)
   );

   agc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_cmd (queue_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .head     (head)
   );

   agc_back #(
      .SMOOTH_SHIFT  (SMOOTH_SHIFT),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .head               (head),
      .pop                (queue_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_smoothed_error (rsp_smoothed_error),
      .rsp_gain_code      (rsp_gain_code)
   );

endmodule

>>> rtl/core/agc_checker.sv
// Port-level checker for the receive gain control block and its bind.
module agc_checker #(
   parameter int QUEUE_DEPTH = agc_pkg::QUEUE_DEPTH_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [agc_pkg::ERR_W-1:0]    rsp_smoothed_error,
   input logic [agc_pkg::GAIN_W-1:0]          rsp_gain_code
);
   localparam int LIMIT = QUEUE_DEPTH + 2;
   localparam int CNT_W = $clog2(LIMIT + 2);

   logic [CNT_W-1:0] pending_ff, pending_in;
   logic             in_word, out_word;

   assign in_word  = req_valid && req_ready;
   assign out_word = rsp_valid && rsp_ready;

   // Track words accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (in_word && !out_word) begin
         pending_in = pending_ff + 1'b1;
      end else if (out_word && !in_word) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_smoothed_error) && $stable(rsp_gain_code))
      else $error("stalled result word changed");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result word without an accepted item");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CNT_W'(LIMIT))
      else $error("more words in flight than the block can hold");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> pending_ff != '0)
      else $error("input stalled with no work in flight");

endmodule

bind receive_gain_agc_with_iir_smoothing agc_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_agc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_smoothed_error (rsp_smoothed_error),
   .rsp_gain_code      (rsp_gain_code)
);
